/* rtl/pwdc_pkg.sv */
// Shared types, constants and register indexes of the PID controller block.
package pwdc_pkg;

  // Field widths
  localparam int MeasW    = 10;
  localparam int ErrW     = 11;
  localparam int SumW     = 18;
  localparam int DiffW    = 12;
  localparam int GainW    = 16;
  localparam int RatioW   = 8;
  localparam int DriveW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;
  localparam int PProdW   = GainW + 1 + ErrW;
  localparam int IProdW   = GainW + 1 + SumW;
  localparam int DProdW   = GainW + 1 + DiffW;
  localparam int AccW     = 36;

  // Default fraction bits of the gains
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND_RATIO = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_LIMIT = 3'd4;

  // Register reset values
  localparam logic [GainW-1:0]  PROP_GAIN_RST      = 16'd256;
  localparam logic [GainW-1:0]  INTEG_GAIN_RST     = 16'd0;
  localparam logic [GainW-1:0]  DERIV_GAIN_RST     = 16'd0;
  localparam logic [RatioW-1:0] DEADBAND_RATIO_RST = 8'd26;
  localparam logic [GainW-1:0]  INTEGRAL_LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [RatioW-1:0] deadband_ratio;
    logic [GainW-1:0]  integral_limit;
  } cfg_t;

  typedef struct packed {
    logic             clear_history;
    logic [MeasW-1:0] setpoint;
    logic [MeasW-1:0] measurement;
  } sample_t;

  // Error stage result
  typedef struct packed {
    logic                    in_deadband;
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  sum;
    logic signed [DiffW-1:0] diff;
  } err_t;

  // Product stage result
  typedef struct packed {
    logic                     in_deadband;
    logic signed [PProdW-1:0] p_prod;
    logic signed [IProdW-1:0] i_prod;
    logic signed [DProdW-1:0] d_prod;
  } prod_t;

endpackage

/* rtl/pwdc_err_stage.sv */
// Error, deadband test and integral/previous-error state update.
module pwdc_err_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pwdc_pkg::cfg_t    cfg,
  input  pwdc_pkg::sample_t smp,
  output pwdc_pkg::err_t    res
);
  import pwdc_pkg::*;

  logic signed [SumW-1:0]   error_sum;
  logic signed [ErrW-1:0]   previous_error;
  logic signed [SumW-1:0]   error_sum_next;
  logic signed [ErrW-1:0]   previous_error_next;
  logic signed [ErrW-1:0]   err;
  logic [MeasW-1:0]         mag;
  logic [SumW-1:0]          band_lhs;
  logic [SumW-1:0]          band_rhs;
  logic                     in_band;
  logic signed [SumW-1:0]   es;
  logic signed [ErrW-1:0]   pe;
  logic signed [SumW:0]     sum_raw;
  logic signed [SumW:0]     lim;
  logic signed [SumW:0]     neg_lim;
  logic signed [SumW:0]     sum_sat;
  logic signed [DiffW-1:0]  diff;
  err_t                     res_next;

  // Form error and test the deadband
  always_comb begin
    err      = $signed({1'b0, smp.measurement}) - $signed({1'b0, smp.setpoint});
    mag      = err[ErrW-1] ? MeasW'(-err) : err[MeasW-1:0];
    band_lhs = {mag, 8'd0};
    band_rhs = {{MeasW{1'b0}}, cfg.deadband_ratio} * {{RatioW{1'b0}}, smp.setpoint};
    in_band  = band_lhs < band_rhs;
  end

  // Clear history first, then accumulate with clamp
  always_comb begin
    es      = smp.clear_history ? '0 : error_sum;
    pe      = smp.clear_history ? '0 : previous_error;
    sum_raw = {es[SumW-1], es} + {{(SumW+1-ErrW){err[ErrW-1]}}, err};
    lim     = $signed({3'b000, cfg.integral_limit});
    neg_lim = -lim;
    if (sum_raw > lim) begin
      sum_sat = lim;
    end else if (sum_raw < neg_lim) begin
      sum_sat = neg_lim;
    end else begin
      sum_sat = sum_raw;
    end
    diff = {err[ErrW-1], err} - {pe[ErrW-1], pe};

    if (in_band) begin
      error_sum_next      = es;
      previous_error_next = pe;
    end else begin
      error_sum_next      = sum_sat[SumW-1:0];
      previous_error_next = err;
    end

    res_next.in_deadband = in_band;
    res_next.err         = err;
    res_next.sum         = sum_sat[SumW-1:0];
    res_next.diff        = diff;
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (load) begin
      error_sum      <= error_sum_next;
      previous_error <= previous_error_next;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/pwdc_mult_stage.sv */
// Gain multiplications for the proportional, integral and derivative terms.
module pwdc_mult_stage (
  input  logic           clk,
  input  logic           load,
  input  pwdc_pkg::cfg_t cfg,
  input  pwdc_pkg::err_t din,
  output pwdc_pkg::prod_t res
);
  import pwdc_pkg::*;

  prod_t res_next;

  // Unsigned gains times signed terms
  always_comb begin
    res_next.in_deadband = din.in_deadband;
    res_next.p_prod      = $signed({1'b0, cfg.prop_gain}) * din.err;
    res_next.i_prod      = $signed({1'b0, cfg.integ_gain}) * din.sum;
    res_next.d_prod      = $signed({1'b0, cfg.deriv_gain}) * din.diff;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

/* rtl/pwdc_sat_stage.sv */
// Term sum, scaling toward zero and int16 saturation into the result register.
module pwdc_sat_stage #(
  parameter int GAIN_FRAC_BITS = pwdc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             load,
  input  pwdc_pkg::prod_t                  din,
  output logic [pwdc_pkg::OutDataW-1:0]    res
);
  import pwdc_pkg::*;

  localparam logic [AccW-1:0] PosMax = AccW'(32767);
  localparam logic [AccW-1:0] NegMax = AccW'(32768);

  logic signed [AccW-1:0] acc;
  logic [AccW-1:0]        mag;
  logic [AccW-1:0]        shifted;
  logic [DriveW-1:0]      drive;

  // Sum terms, scale magnitude, saturate
  always_comb begin
    acc     = AccW'(din.p_prod) + AccW'(din.i_prod) + AccW'(din.d_prod);
    mag     = acc[AccW-1] ? AccW'(-acc) : acc;
    shifted = mag >> GAIN_FRAC_BITS;
    if (din.in_deadband) begin
      drive = '0;
    end else if (acc[AccW-1]) begin
      drive = (shifted > NegMax) ? 16'h8000 : DriveW'(AccW'(0) - shifted);
    end else begin
      drive = (shifted > PosMax) ? 16'h7fff : shifted[DriveW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      res <= {{(OutDataW-DriveW-1){1'b0}}, din.in_deadband, drive};
    end
  end

endmodule

/* rtl/pid_with_deadband_and_clamp_top.sv */
// PID controller with deadband and integral clamp: top level.
//
// Input stream (s_axis): one sample per transfer carrying measurement,
// setpoint and a clear-history flag. Output stream (m_axis): one result
// per sample carrying the saturated drive and an in-deadband flag.
// Gains, deadband ratio and integral limit are set through the write port
// (cfg_we, cfg_index, cfg_data) while no sample is in flight.
//
// The datapath is four register stages: input register, error/state
// stage, gain multiply stage, and sum/saturate result register. One
// sample is accepted every cycle while the receiver keeps up; the
// integral and previous error update in the error stage, so the next
// sample sees the updated values.
//
// When the receiver stalls, the stages fill up and s_axis_tready drops
// once all four hold a sample; nothing is lost or repeated.
// Reset empties the pipeline, zeroes the integral and previous error and
// loads the register defaults.
module pid_with_deadband_and_clamp_top #(
  parameter int GAIN_FRAC_BITS = pwdc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] measurement, [19:10] setpoint, [20] clear_history, [23:21] zero
  input  logic [pwdc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] drive, [16] in_deadband, [23:17] zero
  output logic [pwdc_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [pwdc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pwdc_pkg::CfgDataW-1:0]   cfg_data
);
  import pwdc_pkg::*;

  cfg_t    cfg;
  sample_t in_q;
  err_t    err_q;
  prod_t   prod_q;
  logic    s0_v, s1_v, s2_v, s3_v;
  logic    s1_ready, s2_ready, s3_ready;
  logic    s0_load, s1_load, s2_load, s3_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= PROP_GAIN_RST;
      cfg.integ_gain     <= INTEG_GAIN_RST;
      cfg.deriv_gain     <= DERIV_GAIN_RST;
      cfg.deadband_ratio <= DEADBAND_RATIO_RST;
      cfg.integral_limit <= INTEGRAL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data;
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data;
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data;
        REG_DEADBAND_RATIO: cfg.deadband_ratio <= cfg_data[RatioW-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage advances when the next one is free or moving
  assign s3_ready      = !s3_v || m_axis_tready;
  assign s2_ready      = !s2_v || s3_ready;
  assign s1_ready      = !s1_v || s2_ready;
  assign s_axis_tready = !s0_v || s1_ready;

  assign s0_load = s_axis_tvalid && s_axis_tready;
  assign s1_load = s0_v && s1_ready;
  assign s2_load = s1_v && s2_ready;
  assign s3_load = s2_v && s3_ready;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s0_v <= s_axis_tvalid;
      end
      if (s1_ready) begin
        s1_v <= s0_v;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
      if (s3_ready) begin
        s3_v <= s2_v;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (s0_load) begin
      in_q <= s_axis_tdata[2*MeasW:0];
    end
  end

  pwdc_err_stage u_err (
    .clk  (clk),
    .rst  (rst),
    .load (s1_load),
    .cfg  (cfg),
    .smp  (in_q),
    .res  (err_q)
  );

  pwdc_mult_stage u_mult (
    .clk  (clk),
    .load (s2_load),
    .cfg  (cfg),
    .din  (err_q),
    .res  (prod_q)
  );

  pwdc_sat_stage #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_sat (
    .clk  (clk),
    .load (s3_load),
    .din  (prod_q),
    .res  (m_axis_tdata)
  );

  assign m_axis_tvalid = s3_v;

  // Input side stalls only when every stage holds a sample
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s0_v && s1_v && s2_v && s3_v))
    else $error("input stalled with a free stage");

  // A deadband result always carries a zero drive
  a_band_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[DriveW] |-> (m_axis_tdata[DriveW-1:0] == '0))
    else $error("deadband result with nonzero drive");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A result appears only if the multiply stage held a sample before
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s2_v))
    else $error("result appeared without a source sample");

endmodule

/* tb/tb_pid_with_deadband_and_clamp_top.sv */
// Self-checking testbench for the PID controller with deadband and integral clamp.
`timescale 1ns / 1ps

module tb_pid_with_deadband_and_clamp_top;
  import pwdc_pkg::*;

  localparam int     FRAC         = GAIN_FRAC_BITS_DEF;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_OFF_LEN = 80;
  localparam int     TIMEOUT_NS   = 4_000_000;
  localparam longint DRIVE_MAX    = 32767;
  localparam longint DRIVE_MIN    = -32768;
  // First index past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_BEYOND_LAST = REG_INTEGRAL_LIMIT + 1'b1;

  typedef struct {
    logic signed [DriveW-1:0] drive;
    logic                     in_deadband;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Predictor copy of the registers and the controller state
  logic [GainW-1:0]  kp        = PROP_GAIN_RST;
  logic [GainW-1:0]  ki        = INTEG_GAIN_RST;
  logic [GainW-1:0]  kd        = DERIV_GAIN_RST;
  logic [RatioW-1:0] db_ratio  = DEADBAND_RATIO_RST;
  logic [GainW-1:0]  sum_limit = INTEGRAL_LIMIT_RST;
  int                err_sum   = 0;
  int                last_err  = 0;

  drive_result_t expected_drives[$];
  int            mismatch_count = 0;

  // Idle percentages of the current phase
  int idle_pct  = 0;
  int stall_pct = 0;

  // Long receiver hold-off, requested by the tests and counted by the receiver
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int hold_left         = 0;

  pid_with_deadband_and_clamp_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out drive and deadband flag of one sample; advance the state
  function automatic drive_result_t predict_drive(input sample_t smp);
    int            e;
    int            mag;
    int            diff;
    longint        acc;
    longint        acc_mag;
    drive_result_t res;
    if (smp.clear_history) begin
      err_sum  = 0;
      last_err = 0;
    end
    e   = int'(smp.measurement) - int'(smp.setpoint);
    mag = (e < 0) ? -e : e;
    if (mag * 256 < int'(db_ratio) * int'(smp.setpoint)) begin
      // Inside the deadband: force zero, keep the state
      res.drive       = '0;
      res.in_deadband = 1'b1;
    end else begin
      err_sum = err_sum + e;
      if (err_sum > int'(sum_limit)) begin
        err_sum = int'(sum_limit);
      end else if (err_sum < -int'(sum_limit)) begin
        err_sum = -int'(sum_limit);
      end
      diff     = e - last_err;
      last_err = e;
      acc = longint'(kp) * e + longint'(ki) * err_sum + longint'(kd) * diff;
      // Truncate toward zero, then saturate
      acc_mag = (acc < 0) ? -acc : acc;
      acc_mag = acc_mag >> FRAC;
      if (acc < 0) begin
        res.drive = DriveW'((acc_mag > -DRIVE_MIN) ? DRIVE_MIN : -acc_mag);
      end else begin
        res.drive = DriveW'((acc_mag > DRIVE_MAX) ? DRIVE_MAX : acc_mag);
      end
      res.in_deadband = 1'b0;
    end
    return res;
  endfunction

  // Offer one sample, wait for its transfer and record the expected result
  task automatic send_sample(input logic [MeasW-1:0] meas, input logic [MeasW-1:0] setp,
                             input logic clr);
    sample_t smp;
    smp.measurement   = meas;
    smp.setpoint      = setp;
    smp.clear_history = clr;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    expected_drives.push_back(predict_drive(smp));
  endtask

  // Random sample; a share of them sits close to the setpoint
  task automatic send_random_sample();
    int setp;
    int meas;
    setp = $urandom_range(1023);
    if ($urandom_range(9) < 3) begin
      meas = setp + $urandom_range(80) - 40;
      if (meas < 0) meas = 0;
      if (meas > 1023) meas = 1023;
    end else begin
      meas = $urandom_range(1023);
    end
    send_sample(MeasW'(meas), MeasW'(setp), $urandom_range(15) == 0);
  endtask

  // Drop valid and drain the pipeline before touching the registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:      kp        = val[GainW-1:0];
      REG_INTEG_GAIN:     ki        = val[GainW-1:0];
      REG_DERIV_GAIN:     kd        = val[GainW-1:0];
      REG_DEADBAND_RATIO: db_ratio  = val[RatioW-1:0];
      REG_INTEGRAL_LIMIT: sum_limit = val[GainW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input int p, input int i, input int d, input int r,
                                input int l);
    write_reg(REG_PROP_GAIN, CfgDataW'(p));
    write_reg(REG_INTEG_GAIN, CfgDataW'(i));
    write_reg(REG_DERIV_GAIN, CfgDataW'(d));
    write_reg(REG_DEADBAND_RATIO, CfgDataW'(r));
    write_reg(REG_INTEGRAL_LIMIT, CfgDataW'(l));
  endtask

  // Gain with a random magnitude so that not every product saturates
  function automatic int random_gain();
    return $urandom_range(65535) >> $urandom_range(15);
  endfunction

  task automatic load_setting(input int k);
    case (k)
      0: write_all_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST,
                        DEADBAND_RATIO_RST, INTEGRAL_LIMIT_RST);
      1: write_all_regs(65535, 65535, 65535, 255, 65535);
      2: write_all_regs(0, 0, 0, 0, 0);
      default: write_all_regs(random_gain(), random_gain(), random_gain(),
                              $urandom_range(255), $urandom_range(65535) >> $urandom_range(8));
    endcase
  endtask

  // Reset values: extremes of the fields and a clear inside the deadband
  task automatic test_defaults();
    send_sample(0, 0, 1'b0);
    send_sample(1023, 0, 1'b0);
    send_sample(0, 1023, 1'b0);
    send_sample(1023, 1023, 1'b1);
  endtask

  // Deadband edges, zero ratio, full ratio
  task automatic test_deadband();
    wait_idle();
    write_reg(REG_DEADBAND_RATIO, DEADBAND_RATIO_RST);
    send_sample(256 + 26, 256, 1'b0);
    send_sample(256 + 25, 256, 1'b0);
    send_sample(256 - 25, 256, 1'b1);
    wait_idle();
    write_reg(REG_DEADBAND_RATIO, 0);
    send_sample(500, 500, 1'b0);
    wait_idle();
    write_reg(REG_DEADBAND_RATIO, 255);
    send_sample(1000, 1023, 1'b0);
  endtask

  // Output saturation both ways and truncation toward zero
  task automatic test_saturation();
    wait_idle();
    write_all_regs(65535, 0, 0, 0, INTEGRAL_LIMIT_RST);
    send_sample(1023, 0, 1'b1);
    send_sample(0, 1023, 1'b1);
    wait_idle();
    write_reg(REG_PROP_GAIN, 1);
    send_sample(0, 1, 1'b1);
    send_sample(0, 300, 1'b1);
    send_sample(255, 0, 1'b1);
    wait_idle();
    write_all_regs(0, 0, 65535, 0, INTEGRAL_LIMIT_RST);
    send_sample(1023, 0, 1'b1);
    send_sample(0, 1023, 1'b0);
  endtask

  // Integral clamp, a lowered limit and a zero limit
  task automatic test_integral_clamp();
    wait_idle();
    write_all_regs(0, 256, 0, 0, 1000);
    send_sample(1023, 0, 1'b1);
    send_sample(1023, 0, 1'b0);
    wait_idle();
    write_reg(REG_INTEGRAL_LIMIT, 100);
    send_sample(600, 599, 1'b0);
    wait_idle();
    write_reg(REG_INTEGRAL_LIMIT, 0);
    send_sample(1023, 0, 1'b0);
    send_sample(0, 1023, 1'b0);
  endtask

  // Writes past the last register must leave the settings alone
  task automatic test_reg_index_beyond();
    logic [CfgIdxW-1:0] idx;
    wait_idle();
    write_all_regs(PROP_GAIN_RST, 128, 64, DEADBAND_RATIO_RST, INTEGRAL_LIMIT_RST);
    idx = REG_BEYOND_LAST;
    while (idx >= REG_BEYOND_LAST) begin
      write_reg(idx, '1);
      idx = idx + 1'b1;
    end
    send_sample(700, 200, 1'b1);
    send_sample(100, 900, 1'b0);
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    load_setting(3);
    idle_pct  = 0;
    stall_pct = 0;
    hold_off_requests = hold_off_requests + 1;
    repeat (40) send_random_sample();
  endtask

  // Random traffic under one idling mix, two register settings per phase
  task automatic test_random_traffic(input int idle, input int stall, input int first_setting);
    for (int half = 0; half < 2; half++) begin
      wait_idle();
      load_setting(first_setting + half);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (135) send_random_sample();
    end
  endtask

  // Receiver ready: random stalls plus the requested long hold-off
  always @(posedge clk) begin
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    drive_result_t            exp_res;
    logic signed [DriveW-1:0] got_drive;
    logic                     got_flag;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_drive = m_axis_tdata[DriveW-1:0];
      got_flag  = m_axis_tdata[DriveW];
      if (expected_drives.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got drive %0d in_deadband %0b",
                 $time, got_drive, got_flag);
      end else begin
        exp_res = expected_drives.pop_front();
        if (got_drive !== exp_res.drive) begin
          mismatch_count++;
          $display("%0t: drive expected %0d, got %0d", $time, exp_res.drive, got_drive);
        end
        if (got_flag !== exp_res.in_deadband) begin
          mismatch_count++;
          $display("%0t: in_deadband expected %0b, got %0b",
                   $time, exp_res.in_deadband, got_flag);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_deadband();
    test_saturation();
    test_integral_clamp();
    test_reg_index_beyond();
    test_backpressure();
    test_random_traffic(0, 0, 0);
    test_random_traffic(86, 0, 2);
    test_random_traffic(0, 86, 4);
    test_random_traffic(34, 34, 1);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* pid_with_deadband_and_clamp_top.f */
rtl/pwdc_pkg.sv
rtl/pwdc_err_stage.sv
rtl/pwdc_mult_stage.sv
rtl/pwdc_sat_stage.sv
rtl/pid_with_deadband_and_clamp_top.sv
tb/tb_pid_with_deadband_and_clamp_top.sv
